@@ rtl/rau_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rational unit package
// Opcodes, status codes and the beat type passed from front to back.
// ----------------------------------------------------------------------------
package rau_pkg;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_NEG = 4'd4, OP_ABS = 4'd5, OP_GT = 4'd6, OP_LT = 4'd7,
    OP_EQ = 4'd8, OP_NE = 4'd9, OP_GE = 4'd10, OP_LE = 4'd11
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  // Work handed to the back end: signed magnitude numerator and denominator,
  // or a finished compare result.
  typedef struct packed {
    logic        is_arith;
    logic        n_neg;
    logic [63:0] n_mag;
    logic        d_neg;
    logic [63:0] d_mag;
    logic        truth;
  } work_t;

endpackage
`default_nettype wire

@@ rtl/rau_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rational unit front end
// Decodes one item over a few steps: forms the cross products one multiply
// per cycle, then the numerator sum, and pushes a work beat.
// ----------------------------------------------------------------------------
module rau_front #(
  parameter int WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [3:0]           op,
  input  wire logic signed [31:0]   a_num,
  input  wire logic signed [31:0]   a_den,
  input  wire logic signed [31:0]   b_num,
  input  wire logic signed [31:0]   b_den,
  output logic                      push,
  output rau_pkg::work_t            push_data,
  input  wire logic                 q_full
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001, F_MUL = 4'b0010, F_SUM = 4'b0100, F_PUSH = 4'b1000
  } fstate_t;

  fstate_t     state;
  logic [3:0]  op_r;
  logic [WIDTH-1:0] an_m, ad_m, bn_m, bd_m;
  logic        an_s, ad_s, bn_s, bd_s;
  logic        raw_eq;
  logic [63:0] p0, p1, p2;
  logic        p0s, p1s, p2s;
  logic [1:0]  mcnt;
  rau_pkg::work_t wk;

  function automatic logic [WIDTH-1:0] fmag(input logic [31:0] v);
    logic [WIDTH-1:0] t;
    t = v[WIDTH-1:0];
    return t[WIDTH-1] ? (~t + 1'b1) : t;
  endfunction

  // Multiplier operand select, one product per cycle.
  logic [WIDTH-1:0] mx, my;
  logic             ms;
  logic [63:0]      mp;
  always_comb begin
    mx = an_m; my = bd_m; ms = an_s ^ bd_s;
    case (mcnt)
      2'd0: begin
        mx = an_m; my = bd_m; ms = an_s ^ bd_s;
        if (op_r == rau_pkg::OP_MUL) begin my = bn_m; ms = an_s ^ bn_s; end
      end
      2'd1: begin
        mx = bn_m; my = ad_m; ms = bn_s ^ ad_s;
        if (op_r == rau_pkg::OP_DIV) begin mx = ad_m; my = bn_m; end
      end
      default: begin mx = ad_m; my = bd_m; ms = ad_s ^ bd_s; end
    endcase
    mp = 64'(mx) * 64'(my);
  end

  // Signed magnitude sum of p0 and (+/-)p1.
  logic        s1;
  logic        sum_neg;
  logic [63:0] sum_mag;
  always_comb begin
    s1 = p1s ^ (op_r != rau_pkg::OP_ADD);
    if (p0s == s1) begin
      sum_neg = p0s; sum_mag = p0 + p1;
    end else if (p0 >= p1) begin
      sum_neg = p0s; sum_mag = p0 - p1;
    end else begin
      sum_neg = s1; sum_mag = p1 - p0;
    end
    if (sum_mag == 64'd0) sum_neg = 1'b0;
  end

  // Sign of cross difference times sign of both denominators.
  logic nz, sgn_neg;
  always_comb begin
    nz = (sum_mag != 64'd0) && (ad_m != '0) && (bd_m != '0);
    sgn_neg = sum_neg ^ ad_s ^ bd_s;
  end
  function automatic logic cmp_gt();
    return nz && !sgn_neg;
  endfunction
  function automatic logic cmp_lt();
    return nz && sgn_neg;
  endfunction

  assign busy = (state != F_IDLE);
  assign push = (state == F_PUSH) && !q_full;
  assign push_data = wk;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      mcnt  <= 2'd0;
    end else begin
      case (state)
        F_IDLE: if (start) begin
          state <= F_MUL;
          mcnt  <= 2'd0;
        end
        F_MUL: begin
          mcnt <= mcnt + 2'd1;
          if (mcnt == 2'd2) state <= F_SUM;
        end
        F_SUM: state <= F_PUSH;
        F_PUSH: if (!q_full) state <= F_IDLE;
        default: state <= F_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && start) begin
      op_r <= op;
      an_m <= fmag(a_num); an_s <= a_num[WIDTH-1];
      ad_m <= fmag(a_den); ad_s <= a_den[WIDTH-1];
      bn_m <= fmag(b_num); bn_s <= b_num[WIDTH-1];
      bd_m <= fmag(b_den); bd_s <= b_den[WIDTH-1];
      raw_eq <= (a_num[WIDTH-1:0] == b_num[WIDTH-1:0]) &&
                (a_den[WIDTH-1:0] == b_den[WIDTH-1:0]);
    end
    if (state == F_MUL) begin
      case (mcnt)
        2'd0:    begin p0 <= mp; p0s <= ms; end
        2'd1:    begin p1 <= mp; p1s <= ms; end
        default: begin p2 <= mp; p2s <= ms; end
      endcase
    end
    if (state == F_SUM) begin
      wk.is_arith <= (op_r <= rau_pkg::OP_ABS);
      wk.truth    <= 1'b0;
      wk.n_neg    <= 1'b0; wk.n_mag <= 64'd0;
      wk.d_neg    <= 1'b0; wk.d_mag <= 64'd0;
      case (op_r)
        rau_pkg::OP_ADD, rau_pkg::OP_SUB: begin
          wk.n_neg <= sum_neg; wk.n_mag <= sum_mag;
          wk.d_neg <= p2s; wk.d_mag <= p2;
        end
        rau_pkg::OP_MUL: begin
          wk.n_neg <= p0s; wk.n_mag <= p0;
          wk.d_neg <= p2s; wk.d_mag <= p2;
        end
        rau_pkg::OP_DIV: begin
          wk.n_neg <= p0s; wk.n_mag <= p0;
          wk.d_neg <= p1s; wk.d_mag <= p1;
        end
        rau_pkg::OP_NEG: begin
          wk.n_neg <= !an_s; wk.n_mag <= 64'(an_m);
          wk.d_neg <= ad_s;  wk.d_mag <= 64'(ad_m);
        end
        rau_pkg::OP_ABS: begin
          wk.n_mag <= 64'(an_m); wk.d_mag <= 64'(ad_m);
        end
        rau_pkg::OP_GT:  wk.truth <= cmp_gt();
        rau_pkg::OP_LT:  wk.truth <= cmp_lt();
        rau_pkg::OP_EQ:  wk.truth <= raw_eq;
        rau_pkg::OP_NE:  wk.truth <= !raw_eq;
        rau_pkg::OP_GE:  wk.truth <= !cmp_lt();
        rau_pkg::OP_LE:  wk.truth <= !cmp_gt();
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/rau_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rational unit work queue
// Two-entry queue between front and back end.
// ----------------------------------------------------------------------------
module rau_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire rau_pkg::work_t push_data,
  output logic                full,
  input  wire logic           pop,
  output logic                empty,
  output rau_pkg::work_t      pop_data
);

  rau_pkg::work_t mem [2];
  logic           wp, rp;
  logic [1:0]     cnt;

  assign full     = (cnt == 2'd2);
  assign empty    = (cnt == 2'd0);
  assign pop_data = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop)  rp <= !rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
  end

endmodule
`default_nettype wire

@@ rtl/rau_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rational unit back end
// Binary gcd over 64-bit magnitudes, then restoring division of numerator
// and denominator by the gcd, one quotient bit per cycle; packs the result.
// ----------------------------------------------------------------------------
module rau_back #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             empty,
  input  wire rau_pkg::work_t   wk,
  output logic                  pop,
  output logic                  done,
  output logic signed [31:0]    res_num,
  output logic [30:0]           res_den,
  output logic                  truth,
  output logic [1:0]            status
);

  typedef enum logic [4:0] {
    B_IDLE = 5'b00001, B_GCD = 5'b00010, B_DIVN = 5'b00100,
    B_DIVD = 5'b01000, B_OUT = 5'b10000
  } bstate_t;

  localparam logic [63:0] LIM = 64'd1 << (WIDTH - 1);

  bstate_t     state;
  rau_pkg::work_t w;
  logic [63:0] gx, gy;
  logic [6:0]  sh;
  logic [63:0] g;
  logic [63:0] quo, rem, dvd;
  logic [6:0]  bit_i;
  logic [63:0] nq, dq;

  // Restoring division step.
  logic [64:0] r2;
  logic [64:0] rt;
  always_comb begin
    r2 = {rem, dvd[63]};
    rt = r2 - {1'b0, g};
  end

  logic neg_r;
  assign neg_r = (w.n_neg != w.d_neg) && (nq != 64'd0);

  assign pop = (state == B_IDLE) && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        B_IDLE: if (!empty) begin
          state <= wk.is_arith && wk.d_mag != 64'd0 ? B_GCD : B_OUT;
        end
        B_GCD: if (gx == 64'd0 || gy == 64'd0 || gx == gy) state <= B_DIVN;
        B_DIVN: if (bit_i == 7'd63) state <= B_DIVD;
        B_DIVD: if (bit_i == 7'd63) state <= B_OUT;
        B_OUT: begin
          state <= B_IDLE;
          done  <= 1'b1;
        end
        default: state <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        w <= wk;
        gx <= wk.n_mag; gy <= wk.d_mag; sh <= 7'd0;
      end
      B_GCD: begin
        // Stein step: strip common twos, then odd/even reduction.
        if (gx == 64'd0 || gy == 64'd0 || gx == gy) begin
          g     <= ((gx == 64'd0) ? gy : gx) << sh;
          rem   <= 64'd0; dvd <= w.n_mag; bit_i <= 7'd0; quo <= 64'd0;
        end else if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1; gy <= gy >> 1; sh <= sh + 7'd1;
        end else if (!gx[0]) gx <= gx >> 1;
        else if (!gy[0]) gy <= gy >> 1;
        else if (gx > gy) gx <= (gx - gy) >> 1;
        else gy <= (gy - gx) >> 1;
      end
      B_DIVN, B_DIVD: begin
        if (!rt[64]) begin
          rem <= rt[63:0]; quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= r2[63:0]; quo <= {quo[62:0], 1'b0};
        end
        dvd   <= dvd << 1;
        bit_i <= bit_i + 7'd1;
        if (bit_i == 7'd63) begin
          bit_i <= 7'd0;
          rem   <= 64'd0;
          quo   <= 64'd0;
          dvd   <= w.d_mag;
          if (state == B_DIVN) nq <= {quo[62:0], !rt[64]};
          else dq <= {quo[62:0], !rt[64]};
        end
      end
      B_OUT: begin
        res_num <= 32'sd0; res_den <= 31'd0;
        truth   <= w.truth; status <= rau_pkg::ST_OK;
        if (w.is_arith) begin
          if (w.d_mag == 64'd0) status <= rau_pkg::ST_ZDEN;
          else if (dq > LIM - 64'd1 || (neg_r ? nq > LIM : nq > LIM - 64'd1))
            status <= rau_pkg::ST_OVF;
          else begin
            res_num <= neg_r ? -$signed(nq[31:0]) : $signed(nq[31:0]);
            res_den <= dq[30:0];
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/rational_arithmetic_unit_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction add/sub/mul/div/neg/abs with gcd reduction, and comparisons.
// ----------------------------------------------------------------------------
// Usage:
//   Drive op and the four operand fields and raise start while busy is low;
//   that edge accepts the beat. busy stays high until the front end has
//   handed the decoded beat into the work queue, also waiting while the
//   queue is full, so a new beat may be taken while the back end still
//   reduces the previous one.
//   The front end forms the cross products with one 32x32 multiplier, one
//   product per cycle, then the signed numerator sum.
//   The back end reduces with a binary gcd (its run set by the operand
//   bits) and then divides numerator and denominator by the gcd with a
//   one-bit-per-cycle restoring divider; compare ops and zero denominators
//   skip the gcd and divider.
//   Each result shows on res_num, res_den, truth and status for one cycle
//   with done high; the receiver cannot stall, so the queue only smooths
//   the front against the back. Reset empties the queue and idles both ends.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core #(
  parameter int WIDTH = 32
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [3:0]         op,
  input  wire logic signed [31:0] a_num,
  input  wire logic signed [31:0] a_den,
  input  wire logic signed [31:0] b_num,
  input  wire logic signed [31:0] b_den,
  output logic                    done,
  output logic signed [31:0]      res_num,
  output logic [30:0]             res_den,
  output logic                    truth,
  output logic [1:0]              status
);

  logic           push, full, pop, empty;
  rau_pkg::work_t push_data, pop_data;

  // Front: accept, classify, form products.
  rau_front #(.WIDTH(WIDTH)) u_front (
    .clk, .rst, .start, .busy, .op, .a_num, .a_den, .b_num, .b_den,
    .push, .push_data, .q_full(full)
  );

  // Hold decoded beats between the ends.
  rau_queue u_queue (
    .clk, .rst, .push, .push_data, .full, .pop, .empty, .pop_data
  );

  // Back: reduce and pack.
  rau_back #(.WIDTH(WIDTH)) u_back (
    .clk, .rst, .empty, .wk(pop_data), .pop, .done,
    .res_num, .res_den, .truth, .status
  );

endmodule
`default_nettype wire

@@ rtl/rau_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Rational unit port checker
// Watches the top-level ports for result consistency.
// ----------------------------------------------------------------------------
module rau_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [30:0] res_den,
  input wire logic        truth,
  input wire logic [1:0]  status
);

  // Accepting a beat makes the front busy next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("busy not raised");

  // Status never shows the unused code.
  a_stat: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= rau_pkg::ST_OVF) else $error("bad status");

  // An error result has its denominator and truth cleared.
  a_den: assert property (@(posedge clk) disable iff (rst)
    done && status != rau_pkg::ST_OK |-> res_den == 31'd0 && !truth)
    else $error("error result not cleared");

  // Done is a single-cycle strobe.
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done held");

endmodule

bind rational_arithmetic_unit_core rau_checker u_rau_checker (
  .clk, .rst, .start, .busy, .done, .res_den, .truth, .status
);
`default_nettype wire

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rational arithmetic unit testbench
// Drives opcode and fraction beats into the unit with random gaps. A
// scoreboard predicts each result exactly (64-bit sign/magnitude products,
// Euclidean gcd) and checks every done beat against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIMIT_CYCLES = 2_000_000;

  // Expected outcome of one beat.
  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               truth;
    logic [1:0]         status;
  } fraction_result_t;

  // Signed magnitude value wide enough for any cross product.
  typedef struct {
    bit          neg;
    logic [63:0] mag;
  } sm_t;

  class fraction_scoreboard;
    fraction_result_t pending[$];
    int               errors;

    function sm_t mk(bit neg, logic [63:0] mag);
      sm_t r;
      r.mag = mag;
      r.neg = (mag != 0) ? neg : 1'b0;
      return r;
    endfunction

    function sm_t from_field(logic [31:0] v);
      logic [31:0] m;
      m = -v;
      if (v[31]) return mk(1'b1, {32'd0, m});
      return mk(1'b0, {32'd0, v});
    endfunction

    function sm_t times(sm_t x, sm_t y);
      return mk(x.neg != y.neg, x.mag * y.mag);
    endfunction

    function sm_t plus(sm_t x, sm_t y);
      if (x.neg == y.neg) return mk(x.neg, x.mag + y.mag);
      if (x.mag >= y.mag) return mk(x.neg, x.mag - y.mag);
      return mk(y.neg, y.mag - x.mag);
    endfunction

    function sm_t flip(sm_t x);
      return mk(!x.neg, x.mag);
    endfunction

    function int sign_of(sm_t x);
      if (x.mag == 0) return 0;
      return x.neg ? -1 : 1;
    endfunction

    // Reduce n/d by the gcd and move the sign onto the numerator.
    function fraction_result_t reduce(sm_t n, sm_t d);
      fraction_result_t r;
      logic [63:0] x, y, t, nm, dm;
      logic [63:0] lim;
      bit neg;
      lim = 64'd1 << 31;
      r = '{num: '0, den: '0, truth: 1'b0, status: rau_pkg::ST_OK};
      if (d.mag == 0) begin
        r.status = rau_pkg::ST_ZDEN;
        return r;
      end
      x = n.mag;
      y = d.mag;
      while (y != 0) begin
        t = x % y;
        x = y;
        y = t;
      end
      nm = n.mag / x;
      dm = d.mag / x;
      neg = (n.neg != d.neg) && nm != 0;
      if (dm > lim - 1 || (neg ? nm > lim : nm > lim - 1)) begin
        r.status = rau_pkg::ST_OVF;
        return r;
      end
      r.num = neg ? -nm[31:0] : nm[31:0];
      r.den = dm[30:0];
      return r;
    endfunction

    // Note an accepted input beat: predict its result.
    function void note_input(logic [3:0] opc, logic [31:0] an_f, logic [31:0] ad_f,
                             logic [31:0] bn_f, logic [31:0] bd_f);
      fraction_result_t r;
      sm_t an, ad, bn, bd, diff;
      int s;
      bit gt, lt, eq;
      an = from_field(an_f);
      ad = from_field(ad_f);
      bn = from_field(bn_f);
      bd = from_field(bd_f);
      r = '{num: '0, den: '0, truth: 1'b0, status: rau_pkg::ST_OK};
      diff = plus(times(an, bd), flip(times(bn, ad)));
      s = sign_of(diff) * sign_of(ad) * sign_of(bd);
      gt = s > 0;
      lt = s < 0;
      eq = (an_f == bn_f) && (ad_f == bd_f);
      case (opc)
        rau_pkg::OP_ADD: r = reduce(plus(times(an, bd), times(bn, ad)), times(ad, bd));
        rau_pkg::OP_SUB: r = reduce(diff, times(ad, bd));
        rau_pkg::OP_MUL: r = reduce(times(an, bn), times(ad, bd));
        rau_pkg::OP_DIV: r = reduce(times(an, bd), times(ad, bn));
        rau_pkg::OP_NEG: r = reduce(flip(an), ad);
        rau_pkg::OP_ABS: r = reduce(mk(1'b0, an.mag), mk(1'b0, ad.mag));
        rau_pkg::OP_GT:  r.truth = gt;
        rau_pkg::OP_LT:  r.truth = lt;
        rau_pkg::OP_EQ:  r.truth = eq;
        rau_pkg::OP_NE:  r.truth = !eq;
        rau_pkg::OP_GE:  r.truth = !lt;
        rau_pkg::OP_LE:  r.truth = !gt;
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task check_result(logic signed [31:0] num, logic [30:0] den,
                      logic tr, logic [1:0] st);
      fraction_result_t e;
      if (pending.size() == 0) begin
        report_mismatch("result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (num !== e.num)
        report_mismatch($sformatf("res_num %0d, expected %0d", num, e.num));
      if (den !== e.den)
        report_mismatch($sformatf("res_den %0d, expected %0d", den, e.den));
      if (tr !== e.truth)
        report_mismatch($sformatf("truth %0b, expected %0b", tr, e.truth));
      if (st !== e.status)
        report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
    endtask

    task report_mismatch(string msg);
      errors++;
      if (errors <= 50) $display("mismatch at %0t: %s", $realtime, msg);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic [3:0] op = '0;
  logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  wire busy, done, truth;
  wire signed [31:0] res_num;
  wire [30:0] res_den;
  wire [1:0] status;

  fraction_scoreboard sb = new();
  int unsigned cycle_count = 0;
  int beat_count = 0;

  always #5 clk = ~clk;

  rational_arithmetic_unit_core #(.WIDTH(32)) uut (
    .clk, .rst, .start, .busy, .op, .a_num, .a_den, .b_num, .b_den,
    .done, .res_num, .res_den, .truth, .status
  );

  // Check every done beat; the receiver never stalls.
  always @(posedge clk) begin
    if (!rst && done) sb.check_result(res_num, res_den, truth, status);
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // Pick a field: mostly small values so the gcd reduces, sometimes extremes.
  function automatic logic [31:0] pick_field();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'd0;
      3, 4: return $urandom();
      5: return 32'($signed(-$urandom_range(1, 1000)));
      default: return $urandom_range(0, 60) * (($urandom_range(0, 1)) ? 1 : -1);
    endcase
  endfunction

  // Send one beat: hold start until the unit takes it. start stays high
  // after the accepting edge; the next call drives it again in that step.
  task automatic send_beat(logic [3:0] o, logic [31:0] an, logic [31:0] ad,
                           logic [31:0] bn, logic [31:0] bd, bit allow_gap);
    if (allow_gap) begin
      while ($urandom_range(0, 99) < 32) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    op <= o;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    do @(posedge clk); while (busy);
    sb.note_input(o, an, ad, bn, bd);
    beat_count++;
  endtask

  initial begin
    int wait_cycles;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: every opcode, extremes, zero denominators, overflow.
    for (int o = 0; o < 12; o++)
      send_beat(4'(o), 32'd6, 32'd4, -32'sd3, 32'd9, 1'b0);
    send_beat(rau_pkg::OP_ADD, 32'h7FFF_FFFF, 32'd1, 32'h7FFF_FFFF, 32'd1, 1'b0);
    send_beat(rau_pkg::OP_MUL, 32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1, 1'b0);
    send_beat(rau_pkg::OP_NEG, 32'h8000_0000, 32'd1, 32'd0, 32'd0, 1'b0);
    send_beat(rau_pkg::OP_NEG, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0, 1'b0);
    send_beat(rau_pkg::OP_ABS, 32'h8000_0000, 32'h8000_0000, 32'd0, 32'd0, 1'b0);
    send_beat(rau_pkg::OP_DIV, 32'd5, 32'd3, 32'd0, 32'd7, 1'b0);
    send_beat(rau_pkg::OP_ADD, 32'd1, 32'd0, 32'd2, 32'd3, 1'b0);
    send_beat(rau_pkg::OP_GT, 32'd1, 32'd0, 32'd2, 32'd3, 1'b0);
    send_beat(rau_pkg::OP_LE, 32'd1, 32'd0, 32'd2, 32'd3, 1'b0);
    send_beat(rau_pkg::OP_SUB, 32'd0, 32'hFFFF_FFF9, 32'd0, 32'd5, 1'b0);
    send_beat(rau_pkg::OP_EQ, 32'd2, 32'd4, 32'd1, 32'd2, 1'b0);
    send_beat(4'd12, 32'd1, 32'd1, 32'd1, 32'd1, 1'b0);
    send_beat(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    // Random: a stretch with no gaps in the middle.
    for (int i = 0; i < 800; i++) begin
      logic [31:0] x;
      x = pick_field();
      send_beat($urandom_range(0, 99) < 95 ? 4'($urandom_range(0, 11)) : 4'($urandom()),
                x, pick_field(), ($urandom_range(0, 7) == 0) ? x : pick_field(),
                pick_field(), !(i >= 300 && i < 400));
    end
    start <= 1'b0;

    // Drain: wait for every expected result, then a tail.
    wait_cycles = 0;
    while (sb.pending.size() != 0 && wait_cycles < 20000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (400) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end
endmodule

@@ files.f @@
rtl/rau_pkg.sv
rtl/rau_front.sv
rtl/rau_queue.sv
rtl/rau_back.sv
rtl/rational_arithmetic_unit_core.sv
rtl/rau_checker.sv
test/testbench.sv
